FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SAA_AST_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SAA_AST_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/saa_pkg.sv
// Types, constants and helpers for the skyline atlas allocator
package saa_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int DIM_W  = 11;
	localparam int POS_W  = 10;
	localparam int SUM_W  = DIM_W + 1;
	localparam int ADDR_W = $clog2(MAX_WIDTH);
	localparam int CFG_AW = 3;
	localparam int APB_DW = 32;

	localparam logic [DIM_W-1:0] START_RST = DIM_W'(128);

	typedef enum logic [0:0] {
		REG_START_W = 1'b0,
		REG_START_H = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [DIM_W-1:0] block_w;
		logic [DIM_W-1:0] block_h;
	} req_t;

	typedef struct packed {
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic             fits;
		logic [DIM_W-1:0] cur_width;
		logic [DIM_W-1:0] cur_height;
	} rsp_t;

	typedef struct packed {
		logic             restart;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
	} cfg_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [DIM_W-1:0]  wdata;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic             lt;
		logic             gt;
	} alu_res_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
		input logic [DIM_W-1:0] maxv);
		logic [DIM_W-1:0] r;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > maxv)
			r = maxv;
		else
			r = v;
		return r;
	endfunction

endpackage

FILE: rtl/skyline_atlas_allocator_top.sv
// Top level: register port, column height store and sequencer
//
// Places block_w x block_h rectangles in a skyline atlas of up to 1024 x 1024.
// A request is taken when start is high and busy is low; exactly one result
// follows, shown for a single cycle with done high, which must be captured
// then as there is no way to hold it. A register write during a request
// drops it with no result. Time per request is set by the column scan over
// the height store (one read port, one column per cycle while a window is
// compared): each candidate start reads columns until it is accepted or
// rejected, a rejected column letting the scan jump past it, and the pass is
// repeated after each growth step (up to 20 steps when growing from a 1 x 1
// atlas). A placement then writes block_w columns. After reset and after any
// write to start_width or start_height the store is cleared, one column a
// cycle over all 1024 columns, during which busy stays high. Writing either
// register restarts the atlas at the new size (0 counts as 1, values above
// 1024 as 1024); the register itself reads back the written 11-bit value.
module skyline_atlas_allocator_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [saa_pkg::CFG_AW-1:0]  paddr,
	input  logic [saa_pkg::APB_DW-1:0]  pwdata,
	output logic [saa_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	input  logic                        start,
	output logic                        busy,
	input  saa_pkg::req_t               req,
	output logic                        done,
	output saa_pkg::rsp_t               res
);
	import saa_pkg::*;

	logic [DIM_W-1:0] start_w_q, start_h_q;
	logic [DIM_W-1:0] start_w_d, start_h_d;
	logic             wr_beat;
	reg_idx_t         idx;
	cfg_t             cfg;
	mem_req_t         mem;
	logic [DIM_W-1:0] rdata;

	assign pready  = 1'b1;
	assign wr_beat = psel & penable & pwrite & pready;
	assign idx     = reg_idx_t'(paddr[2]);

	always_comb begin
		start_w_d = start_w_q;
		start_h_d = start_h_q;
		if (wr_beat) begin
			unique case (idx)
				REG_START_W: start_w_d = pwdata[DIM_W-1:0];
				REG_START_H: start_h_d = pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_w_q <= START_RST;
			start_h_q <= START_RST;
		end else begin
			start_w_q <= start_w_d;
			start_h_q <= start_h_d;
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_START_W: prdata = {{(APB_DW-DIM_W){1'b0}}, start_w_q};
			REG_START_H: prdata = {{(APB_DW-DIM_W){1'b0}}, start_h_q};
			default: ;
		endcase
	end

	assign cfg.restart = wr_beat;
	assign cfg.width   = clamp_dim(start_w_d, DIM_W'(MAX_WIDTH));
	assign cfg.height  = clamp_dim(start_h_d, DIM_W'(MAX_HEIGHT));

	saa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.res    (res),
		.mem    (mem),
		.rdata  (rdata)
	);

	saa_ram #(
		.WIDTH (DIM_W),
		.DEPTH (MAX_WIDTH)
	) u_heights (
		.clk   (clk),
		.we    (mem.we),
		.waddr (mem.waddr),
		.wdata (mem.wdata),
		.raddr (mem.raddr),
		.rdata (rdata)
	);

endmodule

FILE: rtl/saa_ram.sv
// Generic single-write, single-read RAM with registered read data
module saa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/saa_alu.sv
// Shared add and compare unit: sum = a + b, compared against c
module saa_alu (
	input  logic [saa_pkg::DIM_W-1:0] a,
	input  logic [saa_pkg::DIM_W-1:0] b,
	input  logic [saa_pkg::DIM_W-1:0] c,
	output saa_pkg::alu_res_t         res
);
	import saa_pkg::*;

	logic [SUM_W-1:0] sum;
	logic [SUM_W-1:0] ref_v;

	assign sum   = {1'b0, a} + {1'b0, b};
	assign ref_v = {1'b0, c};

	assign res.sum = sum;
	assign res.lt  = (sum < ref_v);
	assign res.gt  = (sum > ref_v);

endmodule

FILE: rtl/saa_ctrl.sv
// Sequencer: clearing pass, skyline scan, growth and column update
module saa_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  saa_pkg::cfg_t             cfg,
	input  logic                      start,
	output logic                      busy,
	input  saa_pkg::req_t             req,
	output logic                      done,
	output saa_pkg::rsp_t             res,
	output saa_pkg::mem_req_t         mem,
	input  logic [saa_pkg::DIM_W-1:0] rdata
);
	import saa_pkg::*;

	typedef enum logic [6:0] {
		ST_CLEAR  = 7'b0000001,
		ST_IDLE   = 7'b0000010,
		ST_INIT   = 7'b0000100,
		ST_START  = 7'b0001000,
		ST_CMP    = 7'b0010000,
		ST_DECIDE = 7'b0100000,
		ST_WR     = 7'b1000000
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] clr_q;
	logic [DIM_W-1:0]  w_q, h_q, wd_q, ht_q;
	logic [DIM_W-1:0]  atlas_w_q, atlas_h_q;
	logic [DIM_W-1:0]  best_q, top_q;
	logic [DIM_W-1:0]  i_q, j_q;
	logic [ADDR_W-1:0] addr_q, bx_q;
	logic              found_q;
	logic              done_q;
	rsp_t              res_q;

	logic [DIM_W-1:0]  op_a, op_b, op_c;
	alu_res_t          alu;
	logic [DIM_W-1:0]  top_n;
	logic [SUM_W-1:0]  ht2, wd2;

	saa_alu u_alu (
		.a   (op_a),
		.b   (op_b),
		.c   (op_c),
		.res (alu)
	);

	assign top_n = (rdata > top_q) ? rdata : top_q;
	assign ht2   = {ht_q, 1'b0};
	assign wd2   = {wd_q, 1'b0};

	always_comb begin
		op_a = '0;
		op_b = '0;
		op_c = '0;
		unique case (state_q)
			ST_START: begin
				op_a = i_q;
				op_b = w_q;
				op_c = wd_q;
			end
			ST_CMP: begin
				op_a = rdata;
				op_c = best_q;
			end
			ST_DECIDE, ST_WR: begin
				op_a = best_q;
				op_b = h_q;
				op_c = ht_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		mem.we    = 1'b0;
		mem.waddr = addr_q;
		mem.wdata = alu.sum[DIM_W-1:0];
		mem.raddr = addr_q + ADDR_W'(1);
		unique case (state_q)
			ST_CLEAR: begin
				mem.we    = 1'b1;
				mem.waddr = clr_q;
				mem.wdata = '0;
			end
			ST_START: mem.raddr = i_q[ADDR_W-1:0];
			ST_WR:    mem.we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			atlas_w_q <= clamp_dim(START_RST, DIM_W'(MAX_WIDTH));
			atlas_h_q <= clamp_dim(START_RST, DIM_W'(MAX_HEIGHT));
			done_q    <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg.restart) begin
				atlas_w_q <= cfg.width;
				atlas_h_q <= cfg.height;
				clr_q     <= '0;
				state_q   <= ST_CLEAR;
			end else begin
				unique case (state_q)
					ST_CLEAR: begin
						clr_q <= clr_q + ADDR_W'(1);
						if (clr_q == ADDR_W'(MAX_WIDTH - 1))
							state_q <= ST_IDLE;
					end
					ST_IDLE: begin
						if (start) begin
							w_q     <= req.block_w;
							h_q     <= req.block_h;
							wd_q    <= atlas_w_q;
							ht_q    <= atlas_h_q;
							state_q <= ST_INIT;
						end
					end
					ST_INIT: begin
						best_q  <= ht_q;
						found_q <= 1'b0;
						i_q     <= '0;
						bx_q    <= '0;
						state_q <= ST_START;
					end
					ST_START: begin
						if (alu.lt) begin
							if (w_q == '0) begin
								// empty window: every start is taken, last one wins
								bx_q    <= i_q[ADDR_W-1:0];
								best_q  <= '0;
								found_q <= 1'b1;
								i_q     <= i_q + DIM_W'(1);
							end else begin
								addr_q  <= i_q[ADDR_W-1:0];
								j_q     <= '0;
								top_q   <= '0;
								state_q <= ST_CMP;
							end
						end else begin
							state_q <= ST_DECIDE;
						end
					end
					ST_CMP: begin
						if (!alu.lt) begin
							// every window over this column is no better: skip past it
							i_q     <= {1'b0, addr_q} + DIM_W'(1);
							state_q <= ST_START;
						end else if (j_q == w_q - DIM_W'(1)) begin
							bx_q    <= i_q[ADDR_W-1:0];
							best_q  <= top_n;
							found_q <= 1'b1;
							i_q     <= i_q + DIM_W'(1);
							state_q <= ST_START;
						end else begin
							top_q  <= top_n;
							j_q    <= j_q + DIM_W'(1);
							addr_q <= addr_q + ADDR_W'(1);
						end
					end
					ST_DECIDE: begin
						if (found_q && !alu.gt) begin
							if (w_q == '0) begin
								res_q     <= '{pos_x: bx_q, pos_y: best_q[POS_W-1:0],
									fits: 1'b1, cur_width: wd_q, cur_height: ht_q};
								atlas_w_q <= wd_q;
								atlas_h_q <= ht_q;
								done_q    <= 1'b1;
								state_q   <= ST_IDLE;
							end else begin
								addr_q  <= bx_q;
								j_q     <= '0;
								state_q <= ST_WR;
							end
						end else if (ht_q == wd_q) begin
							if (ht2 > SUM_W'(MAX_HEIGHT)) begin
								res_q   <= '{pos_x: '0, pos_y: '0, fits: 1'b0,
									cur_width: atlas_w_q, cur_height: atlas_h_q};
								done_q  <= 1'b1;
								state_q <= ST_IDLE;
							end else begin
								ht_q    <= ht2[DIM_W-1:0];
								state_q <= ST_INIT;
							end
						end else begin
							if (wd2 > SUM_W'(MAX_WIDTH)) begin
								res_q   <= '{pos_x: '0, pos_y: '0, fits: 1'b0,
									cur_width: atlas_w_q, cur_height: atlas_h_q};
								done_q  <= 1'b1;
								state_q <= ST_IDLE;
							end else begin
								wd_q    <= wd2[DIM_W-1:0];
								state_q <= ST_INIT;
							end
						end
					end
					ST_WR: begin
						addr_q <= addr_q + ADDR_W'(1);
						j_q    <= j_q + DIM_W'(1);
						if (j_q == w_q - DIM_W'(1)) begin
							res_q     <= '{pos_x: bx_q, pos_y: best_q[POS_W-1:0],
								fits: 1'b1, cur_width: wd_q, cur_height: ht_q};
							atlas_w_q <= wd_q;
							atlas_h_q <= ht_q;
							done_q    <= 1'b1;
							state_q   <= ST_IDLE;
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign res  = res_q;

endmodule

FILE: rtl/saa_checker.sv
// Port-level checks on the allocator, bound to the top level
`include "assert_macros.svh"

module saa_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input saa_pkg::rsp_t res
);
	import saa_pkg::*;

	`SAA_AST_NXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
	`SAA_AST_NXT(a_done_single, done, !done, "result strobe held for more than one cycle")
	`SAA_AST_IMP(a_fail_zero_pos, done && !res.fits, res.pos_x == '0 && res.pos_y == '0, "failed placement with non-zero position")
	`SAA_AST_IMP(a_pos_in_atlas, done && res.fits, res.pos_x < res.cur_width, "placed column outside atlas width")
	`SAA_AST_IMP(a_size_nonzero, done, res.cur_width != '0 && res.cur_height != '0, "atlas size reported as zero")

endmodule

bind skyline_atlas_allocator_top saa_checker u_saa_checker (.*);

FILE: bench/tb_skyline_atlas_allocator_top.sv
// Self-checking bench for the skyline atlas allocator: directed and random requests over many atlas sizes
module tb_skyline_atlas_allocator_top;
	import saa_pkg::*;

	localparam int STALL_LIMIT = 2_000_000;
	localparam int RAND_PER_SET = 17;

	logic clk;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [CFG_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic pready;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic done;
	rsp_t res;

	skyline_atlas_allocator_top u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.start   (start),
		.busy    (busy),
		.req     (req),
		.done    (done),
		.res     (res)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// shadow of the atlas
	logic [DIM_W-1:0] skyline [MAX_WIDTH];
	int unsigned atlas_w, atlas_h;
	logic [DIM_W-1:0] cfg_start_w = DIM_W'(128);
	logic [DIM_W-1:0] cfg_start_h = DIM_W'(128);

	req_t rect_queue [$];
	rsp_t placements_due [$];

	int n_fail = 0;
	int n_items = 0;
	int n_results = 0;
	int n_refused = 0;
	int n_restarts = 0;
	int burst_left = 0;
	int gap_left = 0;
	int idle_cycles = 0;

	function automatic int unsigned clamp_size(input int unsigned v, input int unsigned lim);
		if (v == 0)
			return 1;
		if (v > lim)
			return lim;
		return v;
	endfunction

	function automatic void restart_atlas();
		for (int k = 0; k < MAX_WIDTH; k++)
			skyline[k] = '0;
		atlas_w = clamp_size(cfg_start_w, MAX_WIDTH);
		atlas_h = clamp_size(cfg_start_h, MAX_HEIGHT);
	endfunction

	function automatic rsp_t place_rect(input req_t r);
		int unsigned w, h, wd, ht, bx, best, top, c, i, j;
		bit found;
		rsp_t o;
		w = r.block_w;
		h = r.block_h;
		wd = atlas_w;
		ht = atlas_h;
		bx = 0;
		best = 0;
		o = '0;
		while (1) begin
			found = 0;
			best = ht;
			// leftmost start with the lowest roof (last start for an empty window); last start column is never tried
			for (i = 0; i + w < wd; i++) begin
				top = 0;
				for (j = 0; j < w; j++) begin
					c = skyline[i + j];
					if (c >= best)
						break;
					if (c > top)
						top = c;
				end
				if (j == w) begin
					bx = i;
					best = top;
					found = 1;
				end
			end
			if (found && best + h <= ht)
				break;
			if (ht == wd) begin
				if (ht * 2 > MAX_HEIGHT) begin
					o.cur_width = DIM_W'(atlas_w);
					o.cur_height = DIM_W'(atlas_h);
					return o;
				end
				ht = ht * 2;
			end else begin
				if (wd * 2 > MAX_WIDTH) begin
					o.cur_width = DIM_W'(atlas_w);
					o.cur_height = DIM_W'(atlas_h);
					return o;
				end
				wd = wd * 2;
			end
		end
		for (j = 0; j < w; j++)
			skyline[(bx + j) % MAX_WIDTH] = DIM_W'(best + h);
		atlas_w = wd;
		atlas_h = ht;
		o.pos_x = POS_W'(bx);
		o.pos_y = POS_W'(best);
		o.fits = 1'b1;
		o.cur_width = DIM_W'(wd);
		o.cur_height = DIM_W'(ht);
		return o;
	endfunction

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_fail++;
		end
	endtask

	// request driver: bursts of beats with random gaps
	always @(posedge clk or negedge arst_n) begin
		logic taken;
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			taken = start && !busy;
			if (taken) begin
				placements_due.push_back(place_rect(req));
				n_items++;
			end
			if (!start || taken) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					start <= 1'b0;
				end else if (rect_queue.size() > 0) begin
					req <= rect_queue.pop_front();
					start <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= ($urandom_range(3) == 0) ? $urandom_range(10, 30)
							: $urandom_range(1, 5);
						gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			n_results++;
			if (!res.fits)
				n_refused++;
			if (placements_due.size() == 0) begin
				$error("result beat with nothing outstanding");
				n_fail++;
			end else begin
				want = placements_due.pop_front();
				check_field("pos_x", want.pos_x, res.pos_x);
				check_field("pos_y", want.pos_y, res.pos_y);
				check_field("fits", want.fits, res.fits);
				check_field("cur_width", want.cur_width, res.cur_width);
				check_field("cur_height", want.cur_height, res.cur_height);
			end
		end
	end

	// watchdog on cycles with no beat in either direction
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic reg_write(input reg_idx_t idx, input logic [DIM_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		// junk above the field must be dropped
		pwdata <= ($urandom() & 32'hFFFF_F800) | APB_DW'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_START_W)
			cfg_start_w = val;
		else
			cfg_start_h = val;
		restart_atlas();
		n_restarts++;
	endtask

	task automatic reg_read_check(input reg_idx_t idx, input logic [DIM_W-1:0] want);
		logic [APB_DW-1:0] got;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		check_field(idx == REG_START_W ? "start_width" : "start_height", want, got);
	endtask

	task automatic set_atlas(input logic [DIM_W-1:0] sw, input logic [DIM_W-1:0] sh);
		reg_write(REG_START_W, sw);
		reg_write(REG_START_H, sh);
		reg_read_check(REG_START_W, sw);
		reg_read_check(REG_START_H, sh);
	endtask

	task automatic queue_rect(input int unsigned w, input int unsigned h);
		req_t r;
		r.block_w = DIM_W'(w);
		r.block_h = DIM_W'(h);
		rect_queue.push_back(r);
	endtask

	task automatic queue_random(input int n);
		int unsigned k, cap_w, cap_h;
		cap_w = (atlas_w / 8 > 16) ? 16 : ((atlas_w / 8 < 1) ? 1 : atlas_w / 8);
		cap_h = (atlas_h / 4 < 1) ? 1 : atlas_h / 4;
		for (int n_done = 0; n_done < n; n_done++) begin
			k = $urandom_range(99);
			if (k < 6)
				// over-wide noise kept off the slow mid range
				queue_rect($urandom_range(1) ? $urandom_range(1024, 2047) : $urandom_range(63),
					$urandom_range(2047));
			else if (k < 10)
				queue_rect(0, $urandom_range(cap_h));
			else if (k < 14)
				queue_rect($urandom_range(1, cap_w), 0);
			else
				queue_rect($urandom_range(1, cap_w), $urandom_range(1, cap_h));
		end
	endtask

	task automatic wait_drained();
		while (!(rect_queue.size() == 0 && !start && placements_due.size() == 0))
			@(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		logic [DIM_W-1:0] set_w [8];
		logic [DIM_W-1:0] set_h [8];
		restart_atlas();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		reg_read_check(REG_START_W, DIM_W'(128));
		reg_read_check(REG_START_H, DIM_W'(128));

		// defaults: corners of the request fields
		queue_rect(1, 1);
		queue_rect(0, 0);
		queue_rect(0, 5);
		queue_rect(5, 0);
		queue_rect(127, 1);
		queue_rect(128, 1);
		queue_rect(1, 2047);
		queue_rect(2047, 1);
		queue_rect(1024, 1);
		queue_rect(16, 256);
		queue_rect(3, 3);
		queue_rect(1023, 1);
		wait_drained();

		set_w = '{DIM_W'(1), DIM_W'(0), DIM_W'(2047), DIM_W'(1024),
			DIM_W'(64), DIM_W'(300), DIM_W'(5), DIM_W'($urandom_range(2047))};
		set_h = '{DIM_W'(1), DIM_W'(0), DIM_W'(2047), DIM_W'(1024),
			DIM_W'(256), DIM_W'(300), DIM_W'(77), DIM_W'($urandom_range(2047))};
		for (int s = 0; s < 8; s++) begin
			set_atlas(set_w[s], set_h[s]);
			if (s == 0) begin
				queue_rect(1, 1);
				queue_rect(0, 1);
				queue_rect(1, 1);
			end else if (s == 3) begin
				// full-height slab leaves only the untried last column
				queue_rect(1023, 1024);
				queue_rect(1, 1);
				queue_rect(0, 0);
			end
			queue_random(RAND_PER_SET);
			wait_drained();
		end

		repeat (20) @(posedge clk);
		$display("covered %0d requests (%0d refused at the size limit) over %0d atlas restarts,",
			n_items, n_refused, n_restarts);
		$display("sizes 1x1 up to 1024x1024 plus zero-sized and over-limit rectangles");
		if (n_fail == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
